### hdl/glm_pkg.sv
// Shared constants, types and helpers for the grid linear interpolation weight map.
// Used by glm_div and grid_linear_interp_weight_map_unit; no dependencies.
package glm_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 32;

  // Divider: (|num| << 16) + den/2 over den, two quotient bits a cycle
  localparam int DVD_W      = 50;
  localparam int DSR_W      = 32;
  localparam int DIV_ITER   = DVD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);
  localparam int F_W        = DVD_W + 2;

  localparam logic signed [F_W-1:0] ONE_Q16 = F_W'(65536);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SRC_BAD  = 2'd1;
  localparam logic [1:0] ST_TGT_BAD  = 2'd2;
  localparam logic [1:0] ST_FEW_SRC  = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK_RQ, S_WALK_CHK, S_A_RQ, S_A_CHK, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } glm_state_t;

  typedef enum logic [1:0] { M_BELOW, M_ABOVE, M_INSIDE } glm_mode_t;

  // Saturate a wide signed value to the 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [F_W-1:0] v);
    logic signed [F_W-1:0] hi;
    logic signed [F_W-1:0] lo;
    hi = F_W'(64'sh7FFF_FFFF);
    lo = -hi - F_W'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

### hdl/glm_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module glm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/glm_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on glm_pkg.
module glm_div
  import glm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DSR_W-1:0]     rem_r;
  logic [DSR_W-1:0]     dsr_r;
  logic [DVD_W-1:0]     dvd_nxt;
  logic [DSR_W-1:0]     rem_nxt;

  // Two restoring steps; quotient bits shift in behind the dividend
  always_comb begin
    logic [DSR_W:0]   t;
    logic [DVD_W-1:0] d;
    logic [DSR_W-1:0] r;
    d = dvd_r;
    r = rem_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t    = t - {1'b0, dsr_r};
        d[0] = 1'b1;
      end
      r = t[DSR_W-1:0];
    end
    dvd_nxt = d;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### hdl/grid_linear_interp_weight_map_unit.sv
// Grid linear interpolation weight map: source table load and target mapping.
// A load or a rejected target goes from acceptance straight to the output stage; an exact
// hit first walks the frame through the table; extrapolation goes through the divider;
// interpolation walks the frame and then divides. One item is in flight: the next is taken
// only once the last word has gone to the output register, which a held output delays.
// Reset (synchronous, rst_n low) empties the table and clears frame and ordering state.
module grid_linear_interp_weight_map_unit
  import glm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_coord,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [1:0]         out_pair_count,
  output logic [7:0]         out_first_index,
  output logic signed [31:0] out_first_weight,
  output logic [7:0]         out_second_index,
  output logic signed [31:0] out_second_weight
);

  glm_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r;
  logic [IDX_W-1:0]          frame_r;
  logic signed [COORD_W-1:0] last_r;
  logic                      seen_r;
  logic signed [COORD_W-1:0] head0_r, head1_r, tail_r, prev_r;
  logic signed [COORD_W-1:0] coord_r;
  logic signed [COORD_W-1:0] next_r;
  logic signed [COORD_W:0]   num_r;
  logic [DSR_W-1:0]          den_r;
  glm_mode_t                 mode_r;
  logic [IDX_W-1:0]          idx0_r, idx1_r;

  // Pending result word
  logic [1:0]         p_status_r, p_cnt_r;
  logic [7:0]         p_i0_r, p_i1_r;
  logic [COORD_W-1:0] p_w0_r, p_w1_r;

  logic               accept;
  logic               out_free;
  logic [CNT_W-1:0]   eff_cnt;
  logic               load_ok;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic signed [COORD_W-1:0] ram_rdata;
  logic [IDX_W-1:0]   last_idx;
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic [DVD_W-1:0]   dividend;
  logic [COORD_W:0]   mag;
  logic signed [F_W-1:0] f;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  assign eff_cnt = in_restart ? '0 : count_r;
  assign load_ok = (eff_cnt < CNT_W'(MAX_POINTS)) &&
                   ((eff_cnt == '0) || (in_coord > tail_r));

  // Source table memory
  glm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_coord),
    .rdata (ram_rdata)
  );

  // Divider operands
  assign mag      = num_r[COORD_W] ? $unsigned(-num_r) : $unsigned(num_r);
  assign dividend = {1'b0, mag, 16'b0} + DVD_W'(den_r >> 1);

  glm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign f = num_r[COORD_W] ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});

  // Next state and memory control
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = frame_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ram_addr = eff_cnt[IDX_W-1:0];
        if (accept) begin
          if (in_func == FUNC_LOAD) begin
            ram_we    = load_ok;
            state_nxt = S_EMIT;
          end else if (count_r < CNT_W'(2) || (seen_r && in_coord <= last_r)) begin
            state_nxt = S_EMIT;
          end else if (in_coord < head0_r || in_coord > tail_r) begin
            state_nxt = S_DIV_GO;
          end else begin
            state_nxt = S_WALK_RQ;
          end
        end
      end
      S_WALK_RQ: begin
        ram_addr  = frame_r + IDX_W'(1);
        state_nxt = (frame_r == last_idx) ? S_A_RQ : S_WALK_CHK;
      end
      S_WALK_CHK: begin
        state_nxt = (coord_r >= ram_rdata) ? S_WALK_RQ : S_A_RQ;
      end
      S_A_RQ: begin
        ram_addr  = frame_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        state_nxt = (ram_rdata == coord_r) ? S_EMIT : S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      frame_r <= '0;
      seen_r  <= 1'b0;
      last_r  <= '0;
    end else if (accept && in_func == FUNC_LOAD) begin
      if (in_restart) begin
        frame_r <= '0;
        seen_r  <= 1'b0;
      end
      count_r <= load_ok ? eff_cnt + CNT_W'(1) : eff_cnt;
    end else if (accept) begin
      if (count_r >= CNT_W'(2) && !(seen_r && in_coord <= last_r)) begin
        seen_r <= 1'b1;
        last_r <= in_coord;
        if (CNT_W'(frame_r) >= count_r) frame_r <= last_idx;
      end
    end else if (state_r == S_WALK_CHK && coord_r >= ram_rdata) begin
      frame_r <= frame_r + IDX_W'(1);
    end
  end

  // Datapath: edge copies, operands and pending word
  always_ff @(posedge clk) begin
    if (accept && in_func == FUNC_LOAD) begin
      p_status_r <= load_ok ? ST_OK : ST_SRC_BAD;
      p_cnt_r    <= '0;
      p_i0_r     <= '0;
      p_i1_r     <= '0;
      p_w0_r     <= '0;
      p_w1_r     <= '0;
      if (load_ok) begin
        prev_r <= tail_r;
        tail_r <= in_coord;
        if (eff_cnt == CNT_W'(0)) head0_r <= in_coord;
        if (eff_cnt == CNT_W'(1)) head1_r <= in_coord;
      end
    end else if (accept) begin
      coord_r    <= in_coord;
      p_status_r <= (count_r < CNT_W'(2)) ? ST_FEW_SRC :
                    (seen_r && in_coord <= last_r) ? ST_TGT_BAD : ST_OK;
      p_cnt_r    <= '0;
      p_i0_r     <= '0;
      p_i1_r     <= '0;
      p_w0_r     <= '0;
      p_w1_r     <= '0;
      if (in_coord < head0_r) begin
        mode_r <= M_BELOW;
        num_r  <= (COORD_W+1)'(in_coord) - (COORD_W+1)'(head0_r);
        den_r  <= DSR_W'((COORD_W+1)'(head1_r) - (COORD_W+1)'(head0_r));
        idx0_r <= '0;
        idx1_r <= IDX_W'(1);
      end else begin
        mode_r <= (in_coord > tail_r) ? M_ABOVE : M_INSIDE;
        num_r  <= (COORD_W+1)'(in_coord) - (COORD_W+1)'(tail_r);
        den_r  <= DSR_W'((COORD_W+1)'(tail_r) - (COORD_W+1)'(prev_r));
        idx0_r <= last_idx;
        idx1_r <= last_idx - IDX_W'(1);
      end
    end else if (state_r == S_WALK_CHK) begin
      next_r <= ram_rdata;
    end else if (state_r == S_A_CHK) begin
      idx0_r <= frame_r;
      idx1_r <= frame_r + IDX_W'(1);
      num_r  <= (COORD_W+1)'(coord_r) - (COORD_W+1)'(ram_rdata);
      den_r  <= DSR_W'((COORD_W+1)'(next_r) - (COORD_W+1)'(ram_rdata));
      if (ram_rdata == coord_r) begin
        p_cnt_r <= 2'd1;
        p_i0_r  <= 8'(frame_r);
        p_w0_r  <= sat32(ONE_Q16);
      end
    end else if (state_r == S_DIV_WAIT && div_done) begin
      p_cnt_r <= 2'd2;
      p_i0_r  <= 8'(idx0_r);
      p_i1_r  <= 8'(idx1_r);
      if (mode_r == M_ABOVE) begin
        p_w0_r <= sat32(ONE_Q16 + f);
        p_w1_r <= sat32(-f);
      end else begin
        p_w0_r <= sat32(ONE_Q16 - f);
        p_w1_r <= sat32(f);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_status        <= p_status_r;
      out_pair_count    <= p_cnt_r;
      out_first_index   <= p_i0_r;
      out_first_weight  <= p_w0_r;
      out_second_index  <= p_i1_r;
      out_second_weight <= p_w1_r;
    end
  end

endmodule

### verif/tb_top.sv
// Testbench for grid_linear_interp_weight_map_unit: random and directed source/target words
// checked against an in-bench weight predictor. Depends on glm_pkg and the unit RTL.
module tb_top
  import glm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         pair_count;
    logic [7:0]         first_index;
    logic signed [31:0] first_weight;
    logic [7:0]         second_index;
    logic signed [31:0] second_weight;
  } weight_word_t;

  // Weight predictor and store of expected words
  class weight_scoreboard;
    logic signed [31:0] grid[MAX_POINTS];
    int unsigned        grid_count;
    int unsigned        frame;
    logic signed [63:0] last_tgt;
    bit                 tgt_seen;
    weight_word_t       pending[$];
    int unsigned        mismatches;

    function new();
      grid_count = 0; frame = 0; last_tgt = 0; tgt_seen = 0; mismatches = 0;
    endfunction

    // Rounded (num << 16) / den, ties away from zero
    function logic signed [63:0] ratio_q16(logic signed [63:0] num,
                                           logic signed [63:0] den);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (num < 0) ? -num : num;
      q = ((mag << 16) + den / 2) / den;
      return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [31:0] clip32(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function void note_input(logic func, logic signed [31:0] coord, logic restart);
      weight_word_t w;
      logic signed [63:0] c, s0, sl, a, f;
      w = '0;
      c = coord;
      if (func == FUNC_LOAD) begin
        if (restart) begin
          grid_count = 0; frame = 0; tgt_seen = 0;
        end
        if (grid_count >= MAX_POINTS || (grid_count > 0 && c <= grid[grid_count-1]))
          w.status = ST_SRC_BAD;
        else begin
          grid[grid_count] = coord;
          grid_count++;
        end
      end else if (grid_count < 2) begin
        w.status = ST_FEW_SRC;
      end else if (tgt_seen && c <= last_tgt) begin
        w.status = ST_TGT_BAD;
      end else begin
        tgt_seen = 1; last_tgt = c;
        s0 = grid[0]; sl = grid[grid_count-1];
        if (c < s0) begin
          f = ratio_q16(c - s0, 64'(grid[1]) - s0);
          w.pair_count = 2; w.first_index = 0; w.first_weight = clip32(65536 - f);
          w.second_index = 1; w.second_weight = clip32(f);
        end else if (c > sl) begin
          f = ratio_q16(c - sl, sl - 64'(grid[grid_count-2]));
          w.pair_count = 2; w.first_index = 8'(grid_count - 1);
          w.first_weight = clip32(65536 + f);
          w.second_index = 8'(grid_count - 2); w.second_weight = clip32(-f);
        end else begin
          if (frame >= grid_count) frame = grid_count - 1;
          while (frame < grid_count - 1 && c >= grid[frame+1]) frame++;
          a = grid[frame];
          w.first_index = 8'(frame);
          if (a == c) begin
            w.pair_count = 1; w.first_weight = 32'sd65536;
          end else begin
            f = ratio_q16(c - a, 64'(grid[frame+1]) - a);
            w.pair_count = 2; w.first_weight = clip32(65536 - f);
            w.second_index = 8'(frame + 1); w.second_weight = clip32(f);
          end
        end
      end
      pending = {pending, w};
    endfunction

    function void check_result(weight_word_t got);
      weight_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d n=%0d i0=%0d w0=%h i1=%0d w1=%h",
                    " | got st=%0d n=%0d i0=%0d w0=%h i1=%0d w1=%h"},
                   exp_w.status, exp_w.pair_count, exp_w.first_index, exp_w.first_weight,
                   exp_w.second_index, exp_w.second_weight, got.status, got.pair_count,
                   got.first_index, got.first_weight, got.second_index, got.second_weight);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_func, in_restart;
  logic signed [31:0] in_coord;
  logic out_valid, out_stall;
  logic [1:0] out_status, out_pair_count;
  logic [7:0] out_first_index, out_second_index;
  logic signed [31:0] out_first_weight, out_second_weight;

  grid_linear_interp_weight_map_unit uut (.*);

  weight_scoreboard sb = new();
  bit     quiet_phase;   // no idling on either side
  bit     hold_off;      // long receiver hold-off requested
  longint idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Drive one word and wait until it is taken
  task automatic send_word(logic func, logic signed [31:0] coord, logic restart);
    while (!quiet_phase && $urandom_range(99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_func <= func; in_coord <= coord; in_restart <= restart;
    do @(posedge clk); while (in_stall);
    sb.note_input(func, coord, restart);
  endtask

  task automatic send_map(logic signed [31:0] c);
    send_word(FUNC_MAP, c, $urandom_range(1));
  endtask

  // Load a random ascending grid of n points
  task automatic load_grid(int n, int step_max);
    logic signed [31:0] c;
    c = $signed(32'($urandom_range(200000))) - 100000;
    for (int k = 0; k < n; k++) begin
      send_word(FUNC_LOAD, c, k == 0);
      c = c + 1 + $urandom_range(step_max);
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else if (hold_off) out_stall <= 1;
    else out_stall <= !quiet_phase && ($urandom_range(99) < 17);
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_status, out_pair_count, out_first_index, out_first_weight,
                       out_second_index, out_second_weight});
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] t;
    int n;
    int sent;
    rst_n = 0; in_valid = 0; in_func = 0; in_coord = 0; in_restart = 0;
    quiet_phase = 0; hold_off = 0; sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: too few sources, bad loads, extremes, exact hits, errors
    send_word(FUNC_MAP, 32'sd0, 0);
    send_word(FUNC_LOAD, 32'sh8000_0000, 1);
    send_word(FUNC_MAP, 32'sd5, 1);
    send_word(FUNC_LOAD, 32'sh8000_0000, 0);
    send_word(FUNC_LOAD, 32'sh8000_0001, 0);
    send_word(FUNC_LOAD, 32'sh7FFF_FFFF, 0);
    send_word(FUNC_MAP, 32'sh8000_0001, 0);
    send_word(FUNC_MAP, 32'sh8000_0001, 0);
    send_word(FUNC_MAP, 32'sh8000_0002, 0);
    send_word(FUNC_MAP, 32'sh7FFF_FFFF, 0);
    send_word(FUNC_LOAD, 32'sd0, 1);
    send_word(FUNC_LOAD, 32'sd65536, 0);
    send_word(FUNC_LOAD, 32'sd65536, 0);
    send_word(FUNC_MAP, 32'sh8000_0000, 0);
    send_word(FUNC_MAP, 32'sd32768, 0);
    send_word(FUNC_MAP, 32'sd65536, 0);
    send_word(FUNC_LOAD, 32'sd196608, 0);
    send_word(FUNC_MAP, 32'sd100000, 0);
    send_word(FUNC_MAP, 32'sh7FFF_FFFF, 0);
    send_word(FUNC_MAP, 32'sd0, 0);
    send_word(FUNC_LOAD, 32'sd1, 1);
    send_word(FUNC_LOAD, 32'sd2, 0);
    send_word(FUNC_MAP, 32'sh8000_0000, 0);

    // Fill the table to its limit, then one more
    send_word(FUNC_LOAD, 32'sh8000_0000, 1);
    for (int k = 1; k < MAX_POINTS; k++) send_word(FUNC_LOAD, 32'sh8000_0000 + k * 1000, 0);
    send_word(FUNC_LOAD, 32'sh7FFF_0000, 0);
    for (int k = 0; k < 20; k++) send_map(32'sh8000_0000 + k * 12345 + 7);

    // Pressure: receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 8; k++) send_map(32'sh7FFF_0000 + k * 10);
    join

    // Random sets: mostly small grids with ascending targets, some noise
    while (sent <= 1480) begin
      quiet_phase = (sent > 600 && sent < 900);
      n = ($urandom_range(9) == 0) ? $urandom_range(2, 40) : $urandom_range(1, 6);
      load_grid(n, $urandom_range(1) ? 300000 : 40);
      t = $signed(32'($urandom_range(400000))) - 250000;
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(15))
          0: send_map(t - $urandom_range(50));
          1: send_word(FUNC_LOAD, $signed($urandom()), 0);
          2: send_map($signed($urandom()) | 32'sh4000_0000);
          3: send_map(sb.grid[$urandom_range(sb.grid_count - 1)]);
          default: begin
            t = t + 1 + $urandom_range(($urandom_range(3) == 0) ? 200000 : 3000);
            send_map(t);
          end
        endcase
        sent++;
      end
      sent += n;
    end
    in_valid <= 0;
    quiet_phase = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
hdl/glm_pkg.sv
hdl/glm_ram.sv
hdl/glm_div.sv
hdl/grid_linear_interp_weight_map_unit.sv
verif/tb_top.sv
